// ----- design/ppid_pkg.sv -----
// Shared register indexes, fixed widths and the limit configuration type of the PID block.
package ppid_pkg;

  // Widths fixed by the register map and the result format
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BOUND_W   = 31;
  localparam int unsigned DRIVE_W   = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_ON    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_BOUND    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ON       = 3'd6;

  // Limit settings for the integral and the drive
  typedef struct packed {
    logic [BOUND_W-1:0] integral_bound;
    logic               integral_on;
    logic [BOUND_W-1:0] drive_bound;
    logic               drive_on;
  } bound_cfg_t;

endpackage

// ----- design/ppid_step.sv -----
// Single-pass PID datapath: error, saturated and clamped integral, three scaled terms, drive limit.
module ppid_step
  import ppid_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_BITS    = 8,
  parameter int unsigned ACC_WIDTH    = 32
) (
  input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0] measured,
  input  logic signed [SAMPLE_WIDTH-1:0] gain_p,
  input  logic signed [SAMPLE_WIDTH-1:0] gain_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gain_d,
  input  bound_cfg_t                     bcfg,
  input  logic signed [ACC_WIDTH-1:0]    error_sum,
  input  logic signed [SAMPLE_WIDTH:0]   prev_error,
  output logic signed [SAMPLE_WIDTH:0]   error,
  output logic signed [ACC_WIDTH-1:0]    error_sum_nxt,
  output logic signed [DRIVE_W-1:0]      drive
);

  localparam int unsigned EW   = SAMPLE_WIDTH + 1;
  localparam int unsigned DFW  = SAMPLE_WIDTH + 2;
  localparam int unsigned CW0  = (ACC_WIDTH > EW) ? ACC_WIDTH : EW;
  localparam int unsigned CW   = ((CW0 > DRIVE_W) ? CW0 : DRIVE_W) + 2;
  localparam int unsigned PPW  = SAMPLE_WIDTH + EW;
  localparam int unsigned PIW  = SAMPLE_WIDTH + ACC_WIDTH;
  localparam int unsigned PDW  = SAMPLE_WIDTH + DFW;
  localparam int unsigned MAXP = (PIW > PDW) ? PIW : PDW;
  localparam int unsigned SUMW = MAXP + 2;

  localparam logic signed [CW-1:0] ACC_MAX =
    $signed({{(CW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}});
  localparam logic signed [CW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [SUMW-1:0] OUT_MAX =
    $signed({{(SUMW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}});
  localparam logic signed [SUMW-1:0] OUT_MIN = ~OUT_MAX;

  logic signed [CW-1:0]   sum_raw;
  logic signed [CW-1:0]   sum_sat;
  logic signed [CW-1:0]   ibound;
  logic signed [CW-1:0]   sum_lim;
  logic signed [DFW-1:0]  err_diff;
  logic signed [PPW-1:0]  prod_p;
  logic signed [PIW-1:0]  prod_i;
  logic signed [PDW-1:0]  prod_d;
  logic signed [PPW-1:0]  term_p;
  logic signed [PIW-1:0]  term_i;
  logic signed [PDW-1:0]  term_d;
  logic signed [SUMW-1:0] drv_raw;
  logic signed [SUMW-1:0] drv_hi;
  logic signed [SUMW-1:0] drv_lo;
  logic signed [SUMW-1:0] drv_lim;

  // Error of this sample
  assign error = EW'(setpoint) - EW'(measured);

  // Accumulate, saturate to the accumulator range, then apply the optional bound
  assign sum_raw = CW'(error_sum) + CW'(error);
  assign ibound  = $signed({{(CW-BOUND_W){1'b0}}, bcfg.integral_bound});

  always_comb begin
    if (sum_raw > ACC_MAX) begin
      sum_sat = ACC_MAX;
    end else if (sum_raw < ACC_MIN) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = sum_raw;
    end
    sum_lim = sum_sat;
    if (bcfg.integral_on) begin
      if (sum_sat > ibound) begin
        sum_lim = ibound;
      end else if (sum_sat < -ibound) begin
        sum_lim = -ibound;
      end
    end
  end

  assign error_sum_nxt = sum_lim[ACC_WIDTH-1:0];

  // Three products, each floored by the fraction bits
  assign err_diff = DFW'(error) - DFW'(prev_error);
  assign prod_p   = PPW'(gain_p) * PPW'(error);
  assign prod_i   = PIW'(gain_i) * PIW'(error_sum_nxt);
  assign prod_d   = PDW'(gain_d) * PDW'(err_diff);
  assign term_p   = prod_p >>> FRAC_BITS;
  assign term_i   = prod_i >>> FRAC_BITS;
  assign term_d   = prod_d >>> FRAC_BITS;
  assign drv_raw  = SUMW'(term_p) + SUMW'(term_i) + SUMW'(term_d);

  // Limit the drive to the bound or to the 32-bit range
  always_comb begin
    if (bcfg.drive_on) begin
      drv_hi = $signed({{(SUMW-BOUND_W){1'b0}}, bcfg.drive_bound});
      drv_lo = -drv_hi;
    end else begin
      drv_hi = OUT_MAX;
      drv_lo = OUT_MIN;
    end
    if (drv_raw > drv_hi) begin
      drv_lim = drv_hi;
    end else if (drv_raw < drv_lo) begin
      drv_lim = drv_lo;
    end else begin
      drv_lim = drv_raw;
    end
  end

  assign drive = drv_lim[DRIVE_W-1:0];

endmodule

// ----- design/positional_pid_with_limits.sv -----
// Top level of the positional PID controller with integral and drive limits.
//
//  Channel  | Ports                          | Payload (lowest bit first)
//  ---------+--------------------------------+-------------------------------------
//  input    | in_tvalid, in_tready, in_tdata | setpoint, measured, zero fill
//  result   | out_tvalid, out_tready, out_tdata | drive
//  config   | cfg_we, cfg_index, cfg_wdata   | register value, index 0..6
//
// The whole update runs between the input port and the result register, and a
// new sample is taken every cycle the result register is empty or being drained.
// The integral and previous error update on acceptance.
// Reset clears gains, limits, integral, previous error and the result valid flag.
// A stalled result holds; the input then stalls until the result is taken.
module positional_pid_with_limits
  import ppid_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_BITS    = 8,
  parameter int unsigned ACC_WIDTH    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // setpoint, measured, zero fill
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // drive
  output logic [DRIVE_W-1:0]    out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [((SAMPLE_WIDTH > BOUND_W) ? SAMPLE_WIDTH : BOUND_W)-1:0] cfg_wdata
);

  localparam int unsigned EW = SAMPLE_WIDTH + 1;

  logic signed [SAMPLE_WIDTH-1:0] gain_p_r;
  logic signed [SAMPLE_WIDTH-1:0] gain_i_r;
  logic signed [SAMPLE_WIDTH-1:0] gain_d_r;
  bound_cfg_t                     bcfg_r;
  logic signed [ACC_WIDTH-1:0]    error_sum_r;
  logic signed [EW-1:0]           prev_error_r;
  logic                           out_tvalid_r;
  logic [DRIVE_W-1:0]             out_tdata_r;

  logic                           in_accept;
  logic signed [EW-1:0]           error_nxt;
  logic signed [ACC_WIDTH-1:0]    error_sum_nxt;
  logic signed [DRIVE_W-1:0]      drive_nxt;

  // Take a sample whenever the result register is free or draining
  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  ppid_step #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_step (
    .setpoint      ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .measured      ($signed(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .gain_p        (gain_p_r),
    .gain_i        (gain_i_r),
    .gain_d        (gain_d_r),
    .bcfg          (bcfg_r),
    .error_sum     (error_sum_r),
    .prev_error    (prev_error_r),
    .error         (error_nxt),
    .error_sum_nxt (error_sum_nxt),
    .drive         (drive_nxt)
  );

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      bcfg_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:         gain_p_r <= $signed(cfg_wdata[SAMPLE_WIDTH-1:0]);
        REG_GAIN_I:         gain_i_r <= $signed(cfg_wdata[SAMPLE_WIDTH-1:0]);
        REG_GAIN_D:         gain_d_r <= $signed(cfg_wdata[SAMPLE_WIDTH-1:0]);
        REG_INTEGRAL_BOUND: bcfg_r.integral_bound <= cfg_wdata[BOUND_W-1:0];
        REG_INTEGRAL_ON:    bcfg_r.integral_on <= cfg_wdata[0];
        REG_DRIVE_BOUND:    bcfg_r.drive_bound <= cfg_wdata[BOUND_W-1:0];
        REG_DRIVE_ON:       bcfg_r.drive_on <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Advance controller state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      prev_error_r <= '0;
    end else if (in_accept) begin
      error_sum_r  <= error_sum_nxt;
      prev_error_r <= error_nxt;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_tdata_r <= drive_nxt;
    end
  end

  // Checks on the state and result against the limits
  localparam int unsigned CKW = ((ACC_WIDTH > BOUND_W) ? ACC_WIDTH : BOUND_W) + 2;

  logic signed [CKW-1:0] sum_ck;
  logic signed [CKW-1:0] ib_ck;
  logic signed [DRIVE_W:0] drv_ck;
  logic signed [DRIVE_W:0] db_ck;

  assign sum_ck = CKW'(error_sum_r);
  assign ib_ck  = $signed({{(CKW-BOUND_W){1'b0}}, bcfg_r.integral_bound});
  assign drv_ck = (DRIVE_W+1)'($signed(out_tdata_r));
  assign db_ck  = $signed({{(DRIVE_W+1-BOUND_W){1'b0}}, bcfg_r.drive_bound});

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid_r)
    else $error("accepted sample did not produce a result");

  a_integral_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && bcfg_r.integral_on && !cfg_we) |=>
      (sum_ck <= ib_ck && sum_ck >= -ib_ck))
    else $error("integral outside its enabled bound");

  a_drive_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && bcfg_r.drive_on && !cfg_we) |=>
      (drv_ck <= db_ck && drv_ck >= -db_ck))
    else $error("drive outside its enabled bound");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_tdata_r)))
    else $error("stalled result changed");

endmodule
